// ===== sv/pss_pkg.sv =====
// pss_pkg: types, constants and register codes for the polyline segment splitter.
// Used by pss_divider, pss_sqrt and polyline_segment_splitter.
`default_nettype none
package pss_pkg;
    localparam int COORD_W = 26;
    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int DIV_NUM_W = 33;   // widest dividend magnitude
    localparam int DIV_DEN_W = 20;   // widest divisor
    localparam int SQ_IN_W = 54;     // dx*dx + dy*dy, deltas up to 26 bits each
    localparam int SQ_OUT_W = 27;

    typedef enum logic [2:0] {
        REG_DPM    = 3'd0,
        REG_LIMIT  = 3'd1,
        REG_TSPEED = 3'd2,
        REG_DSPEED = 3'd3,
        REG_DPOWER = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CVX, ST_CVY, ST_DIST, ST_SQX, ST_SQY, ST_SQRT,
        ST_NDIV, ST_MIX, ST_PTX, ST_PTY, ST_OUT
    } t_state;

    // unit request / response control
    typedef struct packed {
        logic start;
        logic done;
    } t_unit_ctl;
endpackage
`default_nettype wire

// ===== sv/pss_divider.sv =====
// pss_divider: restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on pss_pkg.
`default_nettype none
module pss_divider (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [pss_pkg::DIV_NUM_W-1:0]  i_num,
    input  wire logic [pss_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                                o_done,
    output logic [pss_pkg::DIV_NUM_W-1:0]       o_quo
);
    import pss_pkg::*;

    logic [DIV_NUM_W-1:0] r_quo, n_quo;
    logic [DIV_DEN_W:0]   r_rem, n_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [5:0]           r_cnt, n_cnt;
    logic                 r_busy, n_busy, r_done, n_done;
    logic [DIV_DEN_W:0]   w_trial;
    logic [DIV_DEN_W+1:0] w_sh;

    // one shift-subtract step
    always_comb begin
        w_sh    = {r_rem, r_quo[DIV_NUM_W-1]};
        w_trial = '0;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = 6'(DIV_NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, 1'b0, r_den}) begin
                w_trial = (DIV_DEN_W+1)'(w_sh - {2'b00, r_den});
                n_rem   = w_trial;
                n_quo   = {r_quo[DIV_NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_sh[DIV_DEN_W:0];
                n_quo = {r_quo[DIV_NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

// ===== sv/pss_sqrt.sv =====
// pss_sqrt: bit-pair integer square root, one result bit per cycle.
// Depends on pss_pkg.
`default_nettype none
module pss_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [pss_pkg::SQ_IN_W-1:0]   i_val,
    output logic                               o_done,
    output logic [pss_pkg::SQ_OUT_W-1:0]       o_root
);
    import pss_pkg::*;

    logic [SQ_IN_W-1:0]  r_val, n_val;
    logic [SQ_OUT_W+1:0] r_rem, n_rem;
    logic [SQ_OUT_W-1:0] r_root, n_root;
    logic [4:0]          r_cnt, n_cnt;
    logic                r_busy, n_busy, r_done, n_done;
    logic [SQ_OUT_W+1:0] w_sh, w_trial;

    // classic remainder method: bring down two bits, try 4*root+1
    always_comb begin
        w_sh    = {r_rem[SQ_OUT_W-1:0], r_val[SQ_IN_W-1 -: 2]};
        w_trial = {r_root, 2'b01};
        n_val   = r_val;
        n_rem   = r_rem;
        n_root  = r_root;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_val  = i_val;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = 5'(SQ_OUT_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_val = {r_val[SQ_IN_W-3:0], 2'b00};
            if (w_sh >= w_trial) begin
                n_rem  = w_sh - w_trial;
                n_root = {r_root[SQ_OUT_W-2:0], 1'b1};
            end else begin
                n_rem  = w_sh;
                n_root = {r_root[SQ_OUT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

// ===== sv/polyline_segment_splitter.sv =====
// polyline_segment_splitter: top level, sequencer around a shared divider and a square root.
// Depends on pss_pkg, pss_divider and pss_sqrt.
`default_nettype none
// Turns polyline vertices in dots into Q10 millimetre moves. One vertex at a
// time: i_stall is raised from the transfer of a vertex until its final move
// has been loaded into the output register. Each coordinate conversion and each
// interpolated coordinate costs one pass of the shared restoring divider, so a
// travel or unsplit draw takes two divider passes, and a split draw adds a square
// root, one divider pass for the count and two divider passes per output point.
// A move waits in the output register while o_stall is high, and the sequencer
// holds before loading the next move until that register is free.
module polyline_segment_splitter #(
    parameter int MAX_SEGMENTS = pss_pkg::DEF_MAX_SEGMENTS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             i_stall,
    input  wire logic        i_cmd,
    input  wire logic signed [15:0] i_vertex_x,
    input  wire logic signed [15:0] i_vertex_y,
    output logic             o_valid,
    input  wire logic        o_stall,
    output logic signed [pss_pkg::COORD_W-1:0] o_move_x,
    output logic signed [pss_pkg::COORD_W-1:0] o_move_y,
    output logic [15:0]      o_move_speed,
    output logic [15:0]      o_move_power,
    output logic             o_last
);
    import pss_pkg::*;

    localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
    localparam int PROD_W = COORD_W + SEG_W + 1;

    // configuration registers
    logic [6:0]  r_dpm;
    logic [19:0] r_limit;
    logic [15:0] r_tspeed, r_dspeed, r_dpower;
    logic        w_wr;
    t_reg_idx    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpm    <= 7'd10;
            r_limit  <= 20'd5120;
            r_tspeed <= '0;
            r_dspeed <= '0;
            r_dpower <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_DPM:    r_dpm    <= pwdata[6:0];
                REG_LIMIT:  r_limit  <= pwdata[19:0];
                REG_TSPEED: r_tspeed <= pwdata[15:0];
                REG_DSPEED: r_dspeed <= pwdata[15:0];
                REG_DPOWER: r_dpower <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DPM:    prdata = {25'd0, r_dpm};
            REG_LIMIT:  prdata = {12'd0, r_limit};
            REG_TSPEED: prdata = {16'd0, r_tspeed};
            REG_DSPEED: prdata = {16'd0, r_dspeed};
            REG_DPOWER: prdata = {16'd0, r_dpower};
            default:    prdata = '0;
        endcase
    end

    // sequencer state
    t_state r_state, n_state;
    logic   r_cmd;
    logic signed [15:0] r_vx, r_vy;
    logic signed [COORD_W-1:0] r_cx, r_cy, r_nx, r_ny, r_px, r_py;
    logic [COORD_W-1:0] r_adx, r_ady;
    logic [SQ_IN_W-1:0] r_sq;
    logic [SEG_W-1:0]   r_n, r_i;
    logic               r_busy_unit;   // a unit request is outstanding
    logic signed [PROD_W-1:0] r_prod;
    logic               r_neg;
    logic               r_ov;
    logic signed [COORD_W-1:0] r_ox, r_oy;
    logic [15:0] r_osp, r_opw;
    logic        r_olast;

    // shared divider request
    t_unit_ctl w_div, w_sq;
    logic [DIV_NUM_W-1:0] w_num;
    logic [DIV_DEN_W-1:0] w_den, w_dpm, w_lim;
    logic [DIV_NUM_W-1:0] w_quo;
    logic [SQ_OUT_W-1:0]  w_root;
    logic signed [COORD_W:0] w_dx, w_dy;
    logic [COORD_W-1:0] w_adx, w_ady;
    logic [COORD_W+1:0] w_man;
    logic signed [COORD_W-1:0] w_q;
    logic [DIV_NUM_W-1:0] w_nq;
    logic [COORD_W-1:0]   w_sqop;
    logic [2*COORD_W-1:0] w_sqp;
    logic                 w_load;

    assign w_dpm = (r_dpm == 7'd0) ? DIV_DEN_W'(1) : DIV_DEN_W'(r_dpm);
    assign w_lim = (r_limit == 20'd0) ? DIV_DEN_W'(1) : r_limit;
    assign w_dx  = (COORD_W+1)'(r_nx) - (COORD_W+1)'(r_cx);
    assign w_dy  = (COORD_W+1)'(r_ny) - (COORD_W+1)'(r_cy);
    assign w_adx = COORD_W'(w_dx[COORD_W] ? -w_dx : w_dx);
    assign w_ady = COORD_W'(w_dy[COORD_W] ? -w_dy : w_dy);
    assign w_man = (COORD_W+2)'(w_adx) + (COORD_W+2)'(w_ady);
    assign w_nq  = r_neg ? -w_quo : w_quo;
    assign w_q   = w_nq[COORD_W-1:0];

    // one squarer shared by both axes
    assign w_sqop = (r_state == ST_SQX) ? r_adx : r_ady;
    assign w_sqp  = (2*COORD_W)'(w_sqop) * (2*COORD_W)'(w_sqop);

    // output register takes a new move once the previous one is gone
    assign w_load = (r_state == ST_OUT) && (!r_ov || !o_stall);

    // divider operands: magnitude plus half divisor, sign kept aside; the count uses root / limit
    always_comb begin
        logic signed [PROD_W:0] v;
        logic [PROD_W:0] m;
        logic [DIV_DEN_W-1:0] d;
        v = '0;
        d = w_dpm;
        case (r_state)
            ST_CVX: v = (PROD_W+1)'(r_vx) <<< 10;
            ST_CVY: v = (PROD_W+1)'(r_vy) <<< 10;
            ST_PTX, ST_PTY: begin
                v = (PROD_W+1)'(r_prod);
                d = DIV_DEN_W'(r_n);
            end
            default: v = '0;
        endcase
        m = v[PROD_W] ? -v : v;
        w_num = DIV_NUM_W'(m) + DIV_NUM_W'(d >> 1);
        w_den = d;
        if (r_state == ST_NDIV) begin
            w_num = DIV_NUM_W'(w_root);
            w_den = w_lim;
        end
    end

    // sign of the pending division
    logic n_neg;
    always_comb begin
        case (r_state)
            ST_CVX: n_neg = r_vx[15];
            ST_CVY: n_neg = r_vy[15];
            ST_PTX, ST_PTY: n_neg = r_prod[PROD_W-1];
            default: n_neg = 1'b0;
        endcase
    end

    logic [SEG_W-1:0] w_ni;
    assign w_ni = r_n - r_i;

    // interpolation numerator i*target + (n-i)*current, one axis at a time
    function automatic logic signed [PROD_W-1:0] f_mix(
        input logic [SEG_W-1:0] a, input logic signed [COORD_W-1:0] t,
        input logic [SEG_W-1:0] b, input logic signed [COORD_W-1:0] c);
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(t) * $signed({1'b0, a}) + PROD_W'(c) * $signed({1'b0, b});
        return p;
    endfunction

    assign w_div.start = (r_state == ST_CVX || r_state == ST_CVY || r_state == ST_NDIV
                          || r_state == ST_PTX || r_state == ST_PTY) && !r_busy_unit;
    assign w_sq.start  = (r_state == ST_SQRT) && !r_busy_unit;

    pss_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div.start),
        .i_num(w_num), .i_den(w_den), .o_done(w_div.done), .o_quo(w_quo)
    );

    pss_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sq.start),
        .i_val(r_sq), .o_done(w_sq.done), .o_root(w_root)
    );

    assign i_stall = (r_state != ST_IDLE);
    assign o_valid = r_ov;
    assign o_move_x = r_ox;
    assign o_move_y = r_oy;
    assign o_move_speed = r_osp;
    assign o_move_power = r_opw;
    assign o_last = r_olast;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_CVX;
            ST_CVX:  if (w_div.done) n_state = ST_CVY;
            ST_CVY:  if (w_div.done) n_state = r_cmd ? ST_DIST : ST_OUT;
            ST_DIST: n_state = (w_man > (COORD_W+2)'(w_lim)) ? ST_SQX : ST_OUT;
            ST_SQX:  n_state = ST_SQY;
            ST_SQY:  n_state = ST_SQRT;
            ST_SQRT: if (w_sq.done) n_state = ST_NDIV;
            ST_NDIV: if (w_div.done) n_state = ST_MIX;
            ST_MIX:  n_state = ST_PTX;
            ST_PTX:  if (w_div.done) n_state = ST_PTY;
            ST_PTY:  if (w_div.done) n_state = ST_OUT;
            ST_OUT:  if (w_load) begin
                if (r_n != '0 && r_i != r_n) n_state = ST_MIX;
                else n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_busy_unit <= 1'b0;
            r_ov        <= 1'b0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_n         <= '0;
            r_i         <= '0;
        end else begin
            r_state <= n_state;
            if (w_div.start || w_sq.start) begin
                r_busy_unit <= 1'b1;
                r_neg       <= n_neg;
            end else if (w_div.done || w_sq.done) begin
                r_busy_unit <= 1'b0;
            end
            if (w_load) r_ov <= 1'b1;
            else if (r_ov && !o_stall) r_ov <= 1'b0;
            case (r_state)
                ST_IDLE: if (i_valid) begin
                    r_cmd <= i_cmd;
                    r_vx  <= i_vertex_x;
                    r_vy  <= i_vertex_y;
                    r_n   <= '0;
                    r_i   <= '0;
                end
                ST_CVX: if (w_div.done) r_nx <= w_q;
                ST_CVY: if (w_div.done) r_ny <= w_q;
                ST_DIST: begin
                    r_adx <= w_adx;
                    r_ady <= w_ady;
                end
                ST_SQX: r_sq <= SQ_IN_W'(w_sqp);
                ST_SQY: r_sq <= r_sq + SQ_IN_W'(w_sqp);
                ST_NDIV: if (w_div.done) begin
                    if (w_quo < DIV_NUM_W'(2)) r_n <= SEG_W'(2);
                    else if (w_quo > DIV_NUM_W'(MAX_SEGMENTS)) r_n <= SEG_W'(MAX_SEGMENTS);
                    else r_n <= SEG_W'(w_quo);
                    r_i <= SEG_W'(1);
                end
                // x numerator ready before the x division starts
                ST_MIX: r_prod <= f_mix(r_i, r_nx, w_ni, r_cx);
                ST_PTX: if (w_div.done) begin
                    r_px   <= w_q;
                    r_prod <= f_mix(r_i, r_ny, w_ni, r_cy);
                end
                ST_PTY: if (w_div.done) r_py <= w_q;
                ST_OUT: if (w_load) begin
                    r_ox    <= (r_n == '0) ? r_nx : r_px;
                    r_oy    <= (r_n == '0) ? r_ny : r_py;
                    r_osp   <= r_cmd ? r_dspeed : r_tspeed;
                    r_opw   <= r_cmd ? r_dpower : 16'd0;
                    r_olast <= (r_n == '0) || (r_i == r_n);
                    if (r_n == '0 || r_i == r_n) begin
                        r_cx <= r_nx;
                        r_cy <= r_ny;
                    end else begin
                        r_i <= r_i + SEG_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
